// File: hw/rtl/e2c_pkg.sv
// e2c_pkg: shared types and constants for the equirect to cube cross resampler
// payload structs, command and register codes, cordic arctangent table
// no dependencies
package e2c_pkg;

	localparam int ANG_W = 24;
	localparam int ANG_PI = 1048576;
	localparam int Z_GAIN = 107922;
	localparam int TAB_LEN = 24;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	localparam logic CFG_FACE_SIZE = 1'b0;
	localparam logic CFG_SOURCE_HEIGHT = 1'b1;

	typedef struct packed {
		logic        action;
		logic [6:0]  load_column;
		logic [5:0]  load_row;
		logic [2:0]  face;
		logic [4:0]  face_u;
		logic [4:0]  face_v;
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic [15:0] alpha_in;
	} item_t;

	typedef struct packed {
		logic [6:0]  cross_column;
		logic [6:0]  cross_row;
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic [15:0] alpha_out;
	} result_t;

	function automatic logic signed [ANG_W-1:0] atan_val(input int k);
		logic signed [ANG_W-1:0] r;
		unique case (k)
			0: r = 24'sd262144;
			1: r = 24'sd154753;
			2: r = 24'sd81767;
			3: r = 24'sd41506;
			4: r = 24'sd20834;
			5: r = 24'sd10427;
			6: r = 24'sd5215;
			7: r = 24'sd2608;
			8: r = 24'sd1304;
			9: r = 24'sd652;
			10: r = 24'sd326;
			11: r = 24'sd163;
			12: r = 24'sd81;
			13: r = 24'sd41;
			14: r = 24'sd20;
			15: r = 24'sd10;
			16: r = 24'sd5;
			17: r = 24'sd3;
			18: r = 24'sd1;
			19: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/equirect_to_cube_cross_resampler.sv
// equirect_to_cube_cross_resampler: top level, face direction, two cordic pipes,
// source coordinate scaling, texel store and bilinear blend; uses e2c_pkg, e2c_cordic
//
// channel   | signals                       | beat taken when
// ----------+-------------------------------+--------------------------
// command   | start, busy, item             | start && !busy
// result    | result_valid, result          | result_valid (no stall)
// config    | cfg_valid, cfg_ready, cfg_*   | cfg_valid && cfg_ready
//
// a compute beat holds the single texel memory port for four reads, a load beat for
// one write; this port sets the sustained rate.
// busy rises only when the texel port is occupied and the last pipe stage holds a beat.
// the texel store is not cleared at reset; unwritten texels read as anything.
module equirect_to_cube_cross_resampler #(
	parameter int MAX_FACE_SIZE = 32,
	parameter int CHANNEL_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  e2c_pkg::item_t  item,
	output logic            result_valid,
	output e2c_pkg::result_t result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [6:0]      cfg_data
);
	import e2c_pkg::*;

	localparam int FS_W = $clog2(MAX_FACE_SIZE + 1);
	localparam int DW = ((FS_W > 6) ? FS_W : 6) + 3;
	localparam int XW = DW + 19;
	localparam int PW = FS_W + ANG_W + 3;
	localparam int COL_W = $clog2(4 * MAX_FACE_SIZE);
	localparam int ROW_W = $clog2(2 * MAX_FACE_SIZE);
	localparam int AD_W = COL_W + ROW_W;
	localparam int CW = (CHANNEL_BITS < 16) ? CHANNEL_BITS : 16;
	localparam int ACC_W = CW + 17;
	localparam int DEPTH = 1 << AD_W;

	localparam logic [2:0] FACE_BACK = 3'd0;
	localparam logic [2:0] FACE_LEFT = 3'd1;
	localparam logic [2:0] FACE_FRONT = 3'd2;
	localparam logic [2:0] FACE_RIGHT = 3'd3;
	localparam logic [2:0] FACE_TOP = 3'd4;
	localparam logic [2:0] FACE_BOTTOM = 3'd5;

	typedef struct packed {
		logic                    is_load;
		logic [AD_W-1:0]         addr;
		logic [4*CW-1:0]         data;
		logic [6:0]              col;
		logic [6:0]              row;
		logic signed [XW-1:0]    zs;
		logic signed [ANG_W-1:0] th;
	} side_t;

	// configuration
	logic [5:0] fs_q;
	logic [6:0] sh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= 6'd32;
			sh_q <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FACE_SIZE: fs_q <= cfg_data[5:0];
				CFG_SOURCE_HEIGHT: sh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [FS_W-1:0]  fs;
	logic [ROW_W:0]   hgt;

	always_comb begin
		if (fs_q == '0) begin
			fs = FS_W'(1);
		end else if (32'(fs_q) > MAX_FACE_SIZE) begin
			fs = FS_W'(MAX_FACE_SIZE);
		end else begin
			fs = FS_W'(fs_q);
		end
		if (sh_q == '0) begin
			hgt = (ROW_W+1)'(1);
		end else if (32'(sh_q) > 2 * MAX_FACE_SIZE) begin
			hgt = (ROW_W+1)'(2 * MAX_FACE_SIZE);
		end else begin
			hgt = (ROW_W+1)'(sh_q);
		end
	end

	// pipeline enable
	logic en;
	logic accept;

	assign busy = !en;
	assign accept = start && en;

	// face direction
	logic signed [DW-1:0] fsd, id, jd, xd, yd, zd;
	logic [DW-1:0]        offx, offy;
	logic                 face_ok;

	always_comb begin
		fsd = DW'($signed({1'b0, fs}));
		id = DW'($signed({1'b0, item.face_u}));
		jd = DW'($signed({1'b0, item.face_v}));
		face_ok = 1'b1;
		xd = '0;
		yd = '0;
		zd = '0;
		offx = '0;
		offy = '0;
		unique case (item.face)
			FACE_BACK: begin
				xd = -fsd; yd = (id <<< 1) - fsd; zd = (jd <<< 1) - fsd;
				offx = fsd; offy = fsd + (fsd <<< 1);
			end
			FACE_LEFT: begin
				xd = (id <<< 1) - fsd; yd = -fsd; zd = fsd - (jd <<< 1);
				offx = '0; offy = fsd;
			end
			FACE_FRONT: begin
				xd = fsd; yd = (id <<< 1) - fsd; zd = fsd - (jd <<< 1);
				offx = fsd; offy = fsd;
			end
			FACE_RIGHT: begin
				xd = fsd - (id <<< 1); yd = fsd; zd = fsd - (jd <<< 1);
				offx = fsd <<< 1; offy = fsd;
			end
			FACE_TOP: begin
				xd = (jd <<< 1) - fsd; yd = (id <<< 1) - fsd; zd = fsd;
				offx = fsd; offy = '0;
			end
			FACE_BOTTOM: begin
				xd = fsd - (jd <<< 1); yd = (id <<< 1) - fsd; zd = -fsd;
				offx = fsd; offy = fsd <<< 1;
			end
			default: face_ok = 1'b0;
		endcase
	end

	logic load_ok;

	assign load_ok = (32'(item.load_column) < 4 * MAX_FACE_SIZE)
		&& (32'(item.load_row) < 2 * MAX_FACE_SIZE);

	// accept stage
	logic                    v_s0;
	logic signed [XW-1:0]    x_s0, y_s0;
	logic signed [ANG_W-1:0] th_s0;
	side_t                   sb_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= accept && ((item.action == ACT_LOAD) ? load_ok : face_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xd < 0) begin
				x_s0 <= XW'(-xd) <<< 16;
				y_s0 <= XW'(-yd) <<< 16;
				th_s0 <= (yd >= 0) ? ANG_W'(ANG_PI) : -ANG_W'(ANG_PI);
			end else begin
				x_s0 <= XW'(xd) <<< 16;
				y_s0 <= XW'(yd) <<< 16;
				th_s0 <= '0;
			end
			sb_s0.is_load <= (item.action == ACT_LOAD);
			sb_s0.addr <= {ROW_W'(item.load_row), COL_W'(item.load_column)};
			sb_s0.data <= {CW'(item.alpha_in), CW'(item.blue_in),
				CW'(item.green_in), CW'(item.red_in)};
			sb_s0.col <= 7'(DW'(id) + offx);
			sb_s0.row <= 7'(DW'(jd) + offy);
			sb_s0.zs <= XW'(zd) * XW'(Z_GAIN);
			sb_s0.th <= '0;
		end
	end

	// longitude
	logic                    c1_v;
	logic signed [XW-1:0]    c1_x, c1_y;
	logic signed [ANG_W-1:0] c1_a;
	side_t                   c1_sb, c2_in_sb;

	e2c_cordic #(.XW(XW), .STEPS(CORDIC_STEPS), .SBW($bits(side_t))) u_cordic_lon (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(v_s0), .in_x(x_s0), .in_y(y_s0), .in_a(th_s0), .in_sb(sb_s0),
		.out_v(c1_v), .out_x(c1_x), .out_y(c1_y), .out_a(c1_a), .out_sb(c1_sb)
	);

	always_comb begin
		c2_in_sb = c1_sb;
		c2_in_sb.th = c1_a;
	end

	// latitude
	logic                    c2_v;
	logic signed [XW-1:0]    c2_x, c2_y;
	logic signed [ANG_W-1:0] c2_a;
	side_t                   c2_sb;

	e2c_cordic #(.XW(XW), .STEPS(CORDIC_STEPS), .SBW($bits(side_t))) u_cordic_lat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(c1_v), .in_x(c1_x), .in_y(c1_sb.zs), .in_a('0), .in_sb(c2_in_sb),
		.out_v(c2_v), .out_x(c2_x), .out_y(c2_y), .out_a(c2_a), .out_sb(c2_sb)
	);

	// source coordinates
	logic signed [PW-1:0] fs2, thp, php, uprod, vprod;

	assign fs2 = PW'($signed({2'b0, fs})) <<< 1;
	assign thp = PW'(c2_sb.th) + PW'(ANG_PI);
	assign php = PW'(ANG_PI / 2) - PW'(c2_a);
	assign uprod = fs2 * thp;
	assign vprod = fs2 * php;

	logic                 v_s1;
	logic signed [PW-1:0] uq_s1, vq_s1;
	side_t                sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= c2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uq_s1 <= uprod >>> 12;
			vq_s1 <= vprod >>> 12;
			sb_s1 <= c2_sb;
		end
	end

	// neighbors and weights
	logic signed [PW-1:0] u1, v1, u2, v2, hi_u, hi_v;
	logic [8:0]           s, t, sn, tn;

	assign u1 = uq_s1 >>> 8;
	assign v1 = vq_s1 >>> 8;
	assign u2 = u1 + PW'(1);
	assign v2 = v1 + PW'(1);
	assign hi_u = (PW'($signed({2'b0, fs})) <<< 2) - PW'(1);
	assign hi_v = PW'($signed({1'b0, hgt})) - PW'(1);
	assign s = {1'b0, uq_s1[7:0]};
	assign t = {1'b0, vq_s1[7:0]};
	assign sn = 9'd256 - s;
	assign tn = 9'd256 - t;

	function automatic logic [PW-1:0] clampv(input logic signed [PW-1:0] v,
		input logic signed [PW-1:0] hi);
		logic [PW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic             v_s2;
	logic [COL_W-1:0] u1_s2, u2_s2;
	logic [ROW_W-1:0] v1_s2, v2_s2;
	logic [16:0]      w_s2 [4];
	side_t            sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u1_s2 <= COL_W'(clampv(u1, hi_u));
			u2_s2 <= COL_W'(clampv(u2, hi_u));
			v1_s2 <= ROW_W'(clampv(v1, hi_v));
			v2_s2 <= ROW_W'(clampv(v2, hi_v));
			w_s2[0] <= 17'(sn) * 17'(tn);
			w_s2[1] <= 17'(s) * 17'(tn);
			w_s2[2] <= 17'(sn) * 17'(t);
			w_s2[3] <= 17'(s) * 17'(t);
			sb_s2 <= sb_s1;
		end
	end

	// texel port sequencer
	logic             hv_q, hload_q;
	logic [1:0]       cnt_q;
	logic [AD_W-1:0]  haddr_q;
	logic [4*CW-1:0]  hdata_q;
	logic [6:0]       hcol_q, hrow_q;
	logic [COL_W-1:0] hu1_q, hu2_q;
	logic [ROW_W-1:0] hv1_q, hv2_q;
	logic [16:0]      hw_q [4];
	logic             take;

	assign take = !hv_q || hload_q || (cnt_q == 2'd3);
	assign en = take || !v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			hv_q <= v_s2;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hload_q <= sb_s2.is_load;
			haddr_q <= sb_s2.addr;
			hdata_q <= sb_s2.data;
			hcol_q <= sb_s2.col;
			hrow_q <= sb_s2.row;
			hu1_q <= u1_s2;
			hu2_q <= u2_s2;
			hv1_q <= v1_s2;
			hv2_q <= v2_s2;
			hw_q <= w_s2;
		end
	end

	logic [AD_W-1:0] raddr;

	always_comb begin
		unique case (cnt_q)
			2'd0: raddr = {hv1_q, hu1_q};
			2'd1: raddr = {hv1_q, hu2_q};
			2'd2: raddr = {hv2_q, hu1_q};
			2'd3: raddr = {hv2_q, hu2_q};
			default: raddr = '0;
		endcase
	end

	logic [4*CW-1:0] mem [DEPTH];
	logic [4*CW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (hv_q && hload_q) begin
			mem[haddr_q] <= hdata_q;
		end
		if (hv_q && !hload_q) begin
			rdata_q <= mem[raddr];
		end
	end

	// read tags
	logic        rv_q, rfirst_q, rlast_q;
	logic [16:0] rw_q;
	logic [6:0]  rcol_q, rrow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else begin
			rv_q <= hv_q && !hload_q;
		end
	end

	always_ff @(posedge clk) begin
		rfirst_q <= (cnt_q == 2'd0);
		rlast_q <= (cnt_q == 2'd3);
		rw_q <= hw_q[cnt_q];
		rcol_q <= hcol_q;
		rrow_q <= hrow_q;
	end

	// blend
	logic [ACC_W-1:0] acc_q [4];
	logic [ACC_W-1:0] sum [4];

	for (genvar c = 0; c < 4; c++) begin : g_chan
		assign sum[c] = (rfirst_q ? '0 : acc_q[c])
			+ ACC_W'(rdata_q[c*CW +: CW]) * ACC_W'(rw_q);

		always_ff @(posedge clk) begin
			if (rv_q) begin
				acc_q[c] <= sum[c];
			end
		end
	end

	logic    res_v_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= rv_q && rlast_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rv_q && rlast_q) begin
			res_q.cross_column <= rcol_q;
			res_q.cross_row <= rrow_q;
			res_q.red_out <= 16'(sum[0] >> 16);
			res_q.green_out <= 16'(sum[1] >> 16);
			res_q.blue_out <= 16'(sum[2] >> 16);
			res_q.alpha_out <= 16'(sum[3] >> 16);
		end
	end

	assign result_valid = res_v_q;
	assign result = res_q;

endmodule

// File: hw/rtl/e2c_cordic.sv
// e2c_cordic: pipelined vectoring cordic, one shift-add step per stage
// carries an opaque sideband word alongside; uses e2c_pkg
module e2c_cordic #(
	parameter int XW = 27,
	parameter int STEPS = 16,
	parameter int SBW = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_v,
	input  logic signed [XW-1:0]             in_x,
	input  logic signed [XW-1:0]             in_y,
	input  logic signed [e2c_pkg::ANG_W-1:0] in_a,
	input  logic [SBW-1:0]                   in_sb,
	output logic                             out_v,
	output logic signed [XW-1:0]             out_x,
	output logic signed [XW-1:0]             out_y,
	output logic signed [e2c_pkg::ANG_W-1:0] out_a,
	output logic [SBW-1:0]                   out_sb
);
	import e2c_pkg::*;

	logic                    v_s  [0:STEPS];
	logic signed [XW-1:0]    x_s  [0:STEPS];
	logic signed [XW-1:0]    y_s  [0:STEPS];
	logic signed [ANG_W-1:0] a_s  [0:STEPS];
	logic [SBW-1:0]          sb_s [0:STEPS];

	assign v_s[0] = in_v;
	assign x_s[0] = in_x;
	assign y_s[0] = in_y;
	assign a_s[0] = in_a;
	assign sb_s[0] = in_sb;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sb_s[k];
				if (y_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					a_s[k+1] <= a_s[k] + atan_val(k);
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					a_s[k+1] <= a_s[k] - atan_val(k);
				end
			end
		end
	end

	assign out_v = v_s[STEPS];
	assign out_x = x_s[STEPS];
	assign out_y = y_s[STEPS];
	assign out_a = a_s[STEPS];
	assign out_sb = sb_s[STEPS];

endmodule
